FILE: hdl/depc_pkg.sv
`default_nettype none

package depc_pkg;

  // Kinds of character position within a date layout.
  typedef logic [1:0] slot_t;
  localparam slot_t SLOT_SEP  = 2'd0;
  localparam slot_t SLOT_DAY  = 2'd1;
  localparam slot_t SLOT_MON  = 2'd2;
  localparam slot_t SLOT_YEAR = 2'd3;

  typedef logic [2:0] layout_t;
  typedef logic [3:0] pos_t;

  // Layout codes as written to the layout register.
  localparam layout_t LAY_DDMMYY   = 3'd0;
  localparam layout_t LAY_DDMMYYYY = 3'd1;
  localparam layout_t LAY_MMDDYY   = 3'd2;
  localparam layout_t LAY_MMDDYYYY = 3'd3;
  localparam layout_t LAY_YYYYMMDD = 3'd4;
  localparam layout_t LAY_YYMMDD   = 3'd5;
  localparam layout_t LAY_SPARE6   = 3'd6;
  localparam layout_t LAY_SPARE7   = 3'd7;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DATE_LAYOUT    = 2'd0;
  localparam cfg_idx_t CFG_SEPARATOR_CHAR = 2'd1;

  localparam layout_t LAYOUT_RESET    = 3'd0;
  localparam logic [7:0] SEP_RESET    = 8'd47;
  localparam pos_t MAX_SLOTS          = 4'd10;
  localparam pos_t POS_MAX            = 4'd15;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [5:0] DAY_MAX      = 6'd31;
  localparam logic [4:0] MONTH_MAX    = 5'd12;
  localparam logic [5:0] DAY_FIRST_MAX   = 6'd3;
  localparam logic [4:0] MONTH_FIRST_MAX = 5'd1;
  localparam logic [3:0] DECIMAL_BASE = 4'd10;

  localparam pos_t LAYOUT_LEN [0:7] = '{
    4'd8, 4'd10, 4'd8, 4'd10, 4'd10, 4'd8, 4'd0, 4'd0
  };

  localparam slot_t LAYOUT_SLOTS [0:7][0:9] = '{
    '{SLOT_DAY,  SLOT_DAY,  SLOT_SEP,  SLOT_MON,  SLOT_MON,
      SLOT_SEP,  SLOT_YEAR, SLOT_YEAR, SLOT_SEP,  SLOT_SEP},
    '{SLOT_DAY,  SLOT_DAY,  SLOT_SEP,  SLOT_MON,  SLOT_MON,
      SLOT_SEP,  SLOT_YEAR, SLOT_YEAR, SLOT_YEAR, SLOT_YEAR},
    '{SLOT_MON,  SLOT_MON,  SLOT_SEP,  SLOT_DAY,  SLOT_DAY,
      SLOT_SEP,  SLOT_YEAR, SLOT_YEAR, SLOT_SEP,  SLOT_SEP},
    '{SLOT_MON,  SLOT_MON,  SLOT_SEP,  SLOT_DAY,  SLOT_DAY,
      SLOT_SEP,  SLOT_YEAR, SLOT_YEAR, SLOT_YEAR, SLOT_YEAR},
    '{SLOT_YEAR, SLOT_YEAR, SLOT_YEAR, SLOT_YEAR, SLOT_SEP,
      SLOT_MON,  SLOT_MON,  SLOT_SEP,  SLOT_DAY,  SLOT_DAY},
    '{SLOT_YEAR, SLOT_YEAR, SLOT_SEP,  SLOT_MON,  SLOT_MON,
      SLOT_SEP,  SLOT_DAY,  SLOT_DAY,  SLOT_SEP,  SLOT_SEP},
    '{SLOT_SEP,  SLOT_SEP,  SLOT_SEP,  SLOT_SEP,  SLOT_SEP,
      SLOT_SEP,  SLOT_SEP,  SLOT_SEP,  SLOT_SEP,  SLOT_SEP},
    '{SLOT_SEP,  SLOT_SEP,  SLOT_SEP,  SLOT_SEP,  SLOT_SEP,
      SLOT_SEP,  SLOT_SEP,  SLOT_SEP,  SLOT_SEP,  SLOT_SEP}
  };

  // Slot kind at a position; positions past the table read as separators,
  // which never matters because the length check fails them first.
  function automatic slot_t slot_at(input layout_t lay, input pos_t pos);
    slot_t s;
    s = SLOT_SEP;
    if (pos < MAX_SLOTS) begin
      s = LAYOUT_SLOTS[lay][pos];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/date_entry_prefix_check_top.sv
`default_nettype none

// Channel  Handshake                   Payload                     Direction
// -------  --------------------------  --------------------------  ---------
// char     char_valid / char_ready     char_code, starts_string    in
// result   result_valid / result_ready prefix_valid                out
// cfg      cfg_valid / cfg_ready       cfg_index, cfg_data         in
//
// Each char beat produces exactly one result beat. The check of a beat is done
// in the cycle it is accepted and lands in the result register, and a new char
// beat can be taken every cycle while the result side does not stall.
// A char beat is taken whenever the result register is empty or is being
// drained in the same cycle; a stall on the result side stalls the char side.
// Reset (synchronous, active high) restores layout 0 and separator '/', and
// clears all string progress. Configuration beats are always taken.

module date_entry_prefix_check_top
  import depc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,

  input  wire logic       char_valid,
  output logic            char_ready,
  input  wire logic [7:0] char_code,
  input  wire logic       starts_string,

  output logic            result_valid,
  input  wire logic       result_ready,
  output logic            prefix_valid,

  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire cfg_idx_t   cfg_index,
  input  wire logic [7:0] cfg_data
);

  // Configuration registers.
  layout_t    date_layout;
  logic [7:0] separator_char;

  // String progress.
  pos_t       position;
  logic [5:0] day_value;
  logic [1:0] day_digit_count;
  logic [4:0] month_value;
  logic [1:0] month_digit_count;
  logic       failed;

  pos_t       position_next;
  logic [5:0] day_value_next;
  logic [1:0] day_digit_count_next;
  logic [4:0] month_value_next;
  logic [1:0] month_digit_count_next;
  logic       failed_next;

  logic       char_beat;
  assign cfg_ready  = 1'b1;
  assign char_ready = !result_valid || result_ready;
  assign char_beat  = char_valid && char_ready;

  // Progress as seen by this beat: a start mark wipes it first.
  pos_t       pos_cur;
  logic [5:0] day_cur;
  logic [1:0] day_cnt_cur;
  logic [4:0] mon_cur;
  logic [1:0] mon_cnt_cur;
  logic       failed_cur;

  logic       in_range;
  slot_t      slot;
  logic       is_digit;
  logic [3:0] digit;
  logic [9:0] day_acc;
  logic [8:0] mon_acc;
  logic [5:0] day_new;
  logic [4:0] mon_new;
  logic       byte_ok;

  always_comb begin
    pos_cur     = starts_string ? '0 : position;
    day_cur     = starts_string ? '0 : day_value;
    day_cnt_cur = starts_string ? '0 : day_digit_count;
    mon_cur     = starts_string ? '0 : month_value;
    mon_cnt_cur = starts_string ? '0 : month_digit_count;
    failed_cur  = starts_string ? 1'b0 : failed;

    in_range = (pos_cur < LAYOUT_LEN[date_layout]);
    slot     = slot_at(date_layout, pos_cur);
    is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    digit    = 4'(char_code - CHAR_ZERO);

    // Decimal accumulate, wrapped to the field width.
    day_acc = ({4'd0, day_cur} * {6'd0, DECIMAL_BASE}) + {6'd0, digit};
    mon_acc = ({4'd0, mon_cur} * {5'd0, DECIMAL_BASE}) + {5'd0, digit};
    day_new = day_acc[5:0];
    mon_new = mon_acc[4:0];

    day_value_next         = day_cur;
    day_digit_count_next   = day_cnt_cur;
    month_value_next       = mon_cur;
    month_digit_count_next = mon_cnt_cur;
    byte_ok                = 1'b0;

    if (!in_range) begin
      byte_ok = 1'b0;
    end else begin
      case (slot)
        SLOT_SEP: begin
          byte_ok = (char_code == separator_char);
        end
        SLOT_DAY: begin
          if (!is_digit) begin
            byte_ok = 1'b0;
          end else if (day_cnt_cur >= 2'd2) begin
            // A third digit into a full field passes and changes nothing.
            byte_ok = 1'b1;
          end else begin
            day_value_next       = day_new;
            day_digit_count_next = day_cnt_cur + 2'd1;
            if (day_cnt_cur == 2'd0) begin
              byte_ok = (day_new <= DAY_FIRST_MAX);
            end else begin
              byte_ok = (day_new >= 6'd1) && (day_new <= DAY_MAX);
            end
          end
        end
        SLOT_MON: begin
          if (!is_digit) begin
            byte_ok = 1'b0;
          end else if (mon_cnt_cur >= 2'd2) begin
            byte_ok = 1'b1;
          end else begin
            month_value_next       = mon_new;
            month_digit_count_next = mon_cnt_cur + 2'd1;
            if (mon_cnt_cur == 2'd0) begin
              byte_ok = (mon_new <= MONTH_FIRST_MAX);
            end else begin
              byte_ok = (mon_new >= 5'd1) && (mon_new <= MONTH_MAX);
            end
          end
        end
        default: begin
          // Year digits are not range checked.
          byte_ok = is_digit;
        end
      endcase
    end

    // A failed string holds its day and month progress.
    if (failed_cur) begin
      day_value_next         = day_cur;
      day_digit_count_next   = day_cnt_cur;
      month_value_next       = mon_cur;
      month_digit_count_next = mon_cnt_cur;
    end
    failed_next   = failed_cur || !byte_ok;
    position_next = (pos_cur < POS_MAX) ? pos_cur + 4'd1 : pos_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      date_layout    <= LAYOUT_RESET;
      separator_char <= SEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DATE_LAYOUT:    date_layout    <= cfg_data[2:0];
        CFG_SEPARATOR_CHAR: separator_char <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position          <= '0;
      day_value         <= '0;
      day_digit_count   <= '0;
      month_value       <= '0;
      month_digit_count <= '0;
      failed            <= 1'b0;
    end else if (char_beat) begin
      position          <= position_next;
      day_value         <= day_value_next;
      day_digit_count   <= day_digit_count_next;
      month_value       <= month_value_next;
      month_digit_count <= month_digit_count_next;
      failed            <= failed_next;
    end
  end

  // Result register: refilled on every char beat, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (char_beat) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_beat) begin
      prefix_valid <= !failed_next;
    end
  end

  // A failed string keeps reporting invalid until a new string starts.
  assert property (@(posedge clk) disable iff (rst)
    (char_beat && !starts_string && failed) |=> (result_valid && !prefix_valid))
    else $error("failed string reported as valid");

  // Unused layout codes have no slots, so every beat fails.
  assert property (@(posedge clk) disable iff (rst)
    (char_beat && (date_layout == LAY_SPARE6 || date_layout == LAY_SPARE7))
      |=> (result_valid && !prefix_valid))
    else $error("unused layout accepted a character");

  // A digit field never counts past two digits.
  assert property (@(posedge clk) disable iff (rst)
    (day_digit_count != 2'd3) && (month_digit_count != 2'd3))
    else $error("digit count overflow");

  // A waiting result blocks new characters.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !char_ready)
    else $error("character taken while result is stalled");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the date prefix checker.
// One process sends char beats and configuration writes in sequence and keeps
// a software copy of the checker state. Every accepted char beat is run
// through that copy, and the predicted prefix_valid is queued. A separate
// process takes each result beat and compares it with the oldest queued value.
module tb_top;
  import depc_pkg::*;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] ASCII_SLASH = 8'h2F;

  logic       clk = 1'b0;
  logic       rst = 1'b1;

  logic       char_valid = 1'b0;
  logic       char_ready;
  logic [7:0] char_code = 8'h00;
  logic       starts_string = 1'b0;

  logic       result_valid;
  logic       result_ready = 1'b0;
  logic       prefix_valid;

  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_idx_t   cfg_index = CFG_DATE_LAYOUT;
  logic [7:0] cfg_data = 8'h00;

  // When set, both sides insert random idle bursts.
  bit idle_on = 1'b0;
  int ready_stall_left = 0;
  int mismatches = 0;

  // Predicted prefix_valid for each char beat that has not come back yet.
  logic expected_prefix_q[$];

  // Software copy of the configuration and of the string progress.
  layout_t    cur_layout = LAY_DDMMYY;
  logic [7:0] cur_sep = ASCII_SLASH;
  pos_t       str_pos = '0;
  logic [5:0] day_acc = '0;
  logic [1:0] day_cnt = '0;
  logic [4:0] mon_acc = '0;
  logic [1:0] mon_cnt = '0;
  logic       str_failed = 1'b0;

  date_entry_prefix_check_top DUT (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_ready    (char_ready),
    .char_code     (char_code),
    .starts_string (starts_string),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .prefix_valid  (prefix_valid),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Number of characters a layout allows; the spare codes allow none.
  function automatic int layout_len(input layout_t lay);
    case (lay)
      LAY_DDMMYY, LAY_MMDDYY, LAY_YYMMDD:       return 8;
      LAY_DDMMYYYY, LAY_MMDDYYYY, LAY_YYYYMMDD: return 10;
      default:                                  return 0;
    endcase
  endfunction

  // Field kind expected at a character position of a layout. Positions past
  // the layout length are caught by the length check before this matters.
  function automatic slot_t slot_kind(input layout_t lay, input pos_t p);
    slot_t k;
    k = SLOT_SEP;
    case (lay)
      LAY_DDMMYY, LAY_DDMMYYYY: begin
        if (p <= 4'd1) k = SLOT_DAY;
        else if (p == 4'd3 || p == 4'd4) k = SLOT_MON;
        else if (p >= 4'd6) k = SLOT_YEAR;
      end
      LAY_MMDDYY, LAY_MMDDYYYY: begin
        if (p <= 4'd1) k = SLOT_MON;
        else if (p == 4'd3 || p == 4'd4) k = SLOT_DAY;
        else if (p >= 4'd6) k = SLOT_YEAR;
      end
      LAY_YYYYMMDD: begin
        if (p <= 4'd3) k = SLOT_YEAR;
        else if (p == 4'd5 || p == 4'd6) k = SLOT_MON;
        else if (p >= 4'd8) k = SLOT_DAY;
      end
      LAY_YYMMDD: begin
        if (p <= 4'd1) k = SLOT_YEAR;
        else if (p == 4'd3 || p == 4'd4) k = SLOT_MON;
        else if (p == 4'd6 || p == 4'd7) k = SLOT_DAY;
      end
      default: k = SLOT_SEP;
    endcase
    return k;
  endfunction

  // Advances the software copy by one character and returns the expected
  // prefix_valid for it.
  function automatic logic predict_prefix(input logic [7:0] c, input logic start);
    logic       ok;
    slot_t      k;
    logic [7:0] dig;
    if (start) begin
      str_pos = '0;
      day_acc = '0;
      day_cnt = '0;
      mon_acc = '0;
      mon_cnt = '0;
      str_failed = 1'b0;
    end
    // Once failed, later characters are not looked at and the day and
    // month progress is frozen.
    if (!str_failed) begin
      ok = 1'b1;
      k = slot_kind(cur_layout, str_pos);
      dig = c - ASCII_ZERO;
      if (int'(str_pos) >= layout_len(cur_layout)) begin
        ok = 1'b0;
      end else if (k == SLOT_SEP) begin
        ok = (c == cur_sep);
      end else if (c < ASCII_ZERO || c > ASCII_NINE) begin
        ok = 1'b0;
      end else if (k == SLOT_DAY) begin
        // A third day digit (after a layout change) passes unchecked.
        if (day_cnt < 2'd2) begin
          day_acc = 6'(day_acc * 10 + dig);
          day_cnt++;
          if (day_cnt == 2'd1) ok = (day_acc <= 6'd3);
          else ok = (day_acc >= 6'd1 && day_acc <= 6'd31);
        end
      end else if (k == SLOT_MON) begin
        if (mon_cnt < 2'd2) begin
          mon_acc = 5'(mon_acc * 10 + dig);
          mon_cnt++;
          if (mon_cnt == 2'd1) ok = (mon_acc <= 5'd1);
          else ok = (mon_acc >= 5'd1 && mon_acc <= 5'd12);
        end
      end
      if (!ok) str_failed = 1'b1;
    end
    if (str_pos != 4'd15) str_pos++;
    return !str_failed;
  endfunction

  // Result side: random stall bursts while idling is enabled, otherwise
  // always ready.
  always @(posedge clk) begin
    if (ready_stall_left != 0) begin
      ready_stall_left <= ready_stall_left - 1;
      result_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      ready_stall_left <= $urandom_range(1, 10) - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Every result beat is matched against the oldest prediction. Values are
  // sampled at the edge, before the design updates its outputs.
  always @(posedge clk) begin
    logic want;
    if (!rst && result_valid && result_ready) begin
      if (expected_prefix_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: result beat with nothing expected, prefix_valid=%0b",
                   $time, prefix_valid);
        end
        mismatches++;
      end else begin
        want = expected_prefix_q.pop_front();
        if (prefix_valid !== want) begin
          if (mismatches < 10) begin
            $display("%0t: prefix_valid mismatch, expected %0b, got %0b",
                     $time, want, prefix_valid);
          end
          mismatches++;
        end
      end
    end
  end

  // Sends one char beat. Valid is left high after acceptance so that a
  // following beat goes out back to back; it is lowered only by an idle
  // burst or by wait_idle.
  task automatic send_char(input logic [7:0] c, input logic start);
    logic predicted;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code <= c;
    starts_string <= start;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    predicted = predict_prefix(c, start);
    expected_prefix_q.insert(expected_prefix_q.size(), predicted);
  endtask

  task automatic send_text(input string s, input logic start_first);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], start_first && i == 0);
    end
  endtask

  // Stops sending and waits until every predicted result has come back.
  // Each char beat yields a result, so the design is idle at that point.
  task automatic wait_idle();
    char_valid <= 1'b0;
    while (expected_prefix_q.size() != 0) @(posedge clk);
  endtask

  // Writes both registers back to back while the design is idle.
  task automatic set_format(input layout_t lay, input logic [7:0] sep);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DATE_LAYOUT;
    cfg_data <= {5'd0, lay};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_layout = lay;
    cfg_index <= CFG_SEPARATOR_CHAR;
    cfg_data <= sep;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_sep = sep;
    cfg_valid <= 1'b0;
  endtask

  // Straight after reset the state is already clear, so the first string
  // needs no start mark. A character past the end of the layout fails.
  task automatic test_first_string_no_start();
    send_text("31/12/99", 1'b0);
    send_char("5", 1'b0);
  endtask

  // The spare layout codes have no positions at all, so any character fails,
  // even one equal to the separator. Both separator extremes are used here.
  task automatic test_unused_layouts();
    set_format(LAY_SPARE6, 8'hFF);
    send_char(8'hFF, 1'b1);
    set_format(LAY_SPARE7, 8'h00);
    send_char(8'h00, 1'b1);
  endtask

  // Year first with a NUL separator: a month of zero fails, and the string
  // then stays failed whatever follows.
  task automatic test_field_limits();
    set_format(LAY_YYYYMMDD, 8'h00);
    send_text("9999", 1'b1);
    send_char(8'h00, 1'b0);
    send_text("00", 1'b0);
    send_char(8'hFF, 1'b0);
  endtask

  // The layout and separator change between two halves of one string. The
  // month already holds two digits, so further month digits pass unchecked.
  task automatic test_config_mid_string();
    set_format(LAY_MMDDYY, "-");
    send_text("12-", 1'b1);
    set_format(LAY_DDMMYY, ".");
    send_text("99", 1'b0);
  endtask

  // Mostly well-formed strings for the current layout with random content
  // and the odd corrupted character, plus strings of random bytes.
  task automatic test_random_strings(input int n_items);
    int         sent;
    int         n_chars;
    int         len;
    int         day_n;
    int         mon_n;
    int         day_first;
    int         mon_first;
    int         d;
    logic       start;
    logic [7:0] c;
    slot_t      k;
    sent = 0;
    while (sent < n_items) begin
      len = layout_len(cur_layout);
      if (len == 0) len = 4;
      start = ($urandom_range(0, 15) != 0);
      if ($urandom_range(0, 9) < 7) begin
        n_chars = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len + 3) : len;
        day_n = 0;
        mon_n = 0;
        day_first = 0;
        mon_first = 0;
        for (int i = 0; i < n_chars; i++) begin
          k = slot_kind(cur_layout, pos_t'(i));
          if (i >= len) begin
            d = $urandom_range(0, 9);
          end else if (k == SLOT_DAY) begin
            if (day_n == 0) d = $urandom_range(0, 3);
            else if (day_first == 0) d = $urandom_range(1, 9);
            else if (day_first == 3) d = $urandom_range(0, 1);
            else d = $urandom_range(0, 9);
            if ($urandom_range(0, 7) == 0) d = $urandom_range(0, 9);
            if (day_n == 0) day_first = d;
            day_n++;
          end else if (k == SLOT_MON) begin
            if (mon_n == 0) d = $urandom_range(0, 1);
            else if (mon_first == 0) d = $urandom_range(1, 9);
            else if (mon_first == 1) d = $urandom_range(0, 2);
            else d = $urandom_range(0, 9);
            if ($urandom_range(0, 7) == 0) d = $urandom_range(0, 9);
            if (mon_n == 0) mon_first = d;
            mon_n++;
          end else begin
            d = $urandom_range(0, 9);
          end
          c = ASCII_ZERO + 8'(d);
          if (i < len && k == SLOT_SEP) begin
            c = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : cur_sep;
          end
          if ($urandom_range(0, 39) == 0) c = 8'($urandom_range(0, 255));
          send_char(c, (i == 0) ? start : ($urandom_range(0, 63) == 0));
        end
      end else begin
        n_chars = $urandom_range(1, 12);
        for (int i = 0; i < n_chars; i++) begin
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end
      sent += n_chars;
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_steady_stream();
    idle_on = 1'b0;
    set_format(LAY_DDMMYYYY, ASCII_SLASH);
    test_random_strings(200);
  endtask

  initial begin
    layout_t    lay;
    logic [7:0] sep;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_first_string_no_start();
    idle_on = 1'b1;
    test_unused_layouts();
    test_field_limits();
    test_config_mid_string();

    // Random phases, each under a fresh setting. Every third phase runs
    // without idling so that long unbroken stretches occur too.
    for (int phase = 0; phase < 10; phase++) begin
      if ($urandom_range(0, 15) == 0) lay = layout_t'($urandom_range(6, 7));
      else lay = layout_t'($urandom_range(0, 5));
      case ($urandom_range(0, 3))
        0:       sep = ASCII_SLASH;
        1:       sep = "-";
        2:       sep = ".";
        default: sep = 8'($urandom_range(0, 255));
      endcase
      set_format(lay, sep);
      idle_on = (phase % 3 != 2);
      test_random_strings(100);
    end

    test_steady_stream();

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_prefix_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
